// ----- sv/swmc_pkg.sv -----
package swmc_pkg;

  localparam int unsigned RES_W     = 8;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned POS_OUT_W = 16;
  localparam int unsigned HOM_W     = 14;
  localparam int unsigned PROD_W    = 20;
  localparam int unsigned DIV_STEPS = 20;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [HOM_W-1:0] HUNDREDTHS_SCALE = 14'd10000;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_START,
    ST_DIVIDE
  } state_e;

  typedef struct packed {
    logic shift;
    logic step;
  } cell_ctrl_t;

endpackage

// ----- sv/sliding_window_mismatch_counter.sv -----
// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_stall_o    req_type, residue, pattern_index, first_residue
// out       source     out_valid_o / out_stall_i  window_start, window_end, match_count,
//                                                 homology_hundredths
// cfg       sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// pattern writes and protein residues whose window is not yet full leave the sequencer idle
// a protein residue with a full window walks the scan chain against the pattern memory
// read port, then runs a 20 step serial divider
// reset empties the window, clears the position and sets length 1, limit 0
// a finished transaction waits in the output register while the next one is taken in

module sliding_window_mismatch_counter #(
  parameter int unsigned MAX_PATTERN   = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [swmc_pkg::RES_W-1:0]           residue_i,
  input  logic [swmc_pkg::IDX_W-1:0]           pattern_index_i,
  input  logic                                 first_residue_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [swmc_pkg::POS_OUT_W-1:0]       window_start_o,
  output logic [swmc_pkg::POS_OUT_W-1:0]       window_end_o,
  output logic [swmc_pkg::LEN_W-1:0]           match_count_o,
  output logic [swmc_pkg::HOM_W-1:0]           homology_hundredths_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [swmc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [swmc_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  swmc_pkg::state_e state_q, state_d;

  logic [swmc_pkg::CFG_W-1:0]     plen_q;
  logic [swmc_pkg::CFG_W-1:0]     limit_q;
  logic [swmc_pkg::LEN_W-1:0]     len_w;

  logic [POSITION_BITS-1:0]       pos_q, pos_d;
  logic [POSITION_BITS-1:0]       pos_base;
  logic [32:0]                    end_w;
  logic [32:0]                    start_w;

  logic [AW-1:0]                  k_q, k_d;
  logic [AW-1:0]                  rd_addr;
  logic [swmc_pkg::LEN_W-1:0]     mism_q, mism_d;
  logic [swmc_pkg::LEN_W-1:0]     mism_next;
  logic [swmc_pkg::LEN_W:0]       cap_w;
  logic [swmc_pkg::LEN_W-1:0]     capped;
  logic [swmc_pkg::LEN_W-1:0]     matches_q;
  logic                           matches_en;
  logic [swmc_pkg::PROD_W-1:0]    product;

  logic [swmc_pkg::POS_OUT_W-1:0] start_q;
  logic [swmc_pkg::POS_OUT_W-1:0] end_q;
  logic                           span_en;

  logic                           in_accept;
  logic                           prot_acc;
  logic                           pat_acc;
  logic                           full;
  logic                           mismatch;
  logic                           div_start;
  logic                           div_done;
  logic [swmc_pkg::HOM_W-1:0]     quot;
  logic                           out_free;
  logic                           out_load;
  logic                           out_valid_q;

  logic [swmc_pkg::RES_W-1:0]     pat_mem [MAX_PATTERN];
  logic [swmc_pkg::RES_W-1:0]     pat_rd_q;
  logic [8:0]                     idx_ext;

  swmc_pkg::cell_ctrl_t           cell_ctrl;
  logic [swmc_pkg::RES_W-1:0]     win_w [MAX_PATTERN];
  logic [swmc_pkg::RES_W-1:0]     cmp_w [MAX_PATTERN];

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= swmc_pkg::CFG_W'(1);
      limit_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        swmc_pkg::CFG_PATTERN_LENGTH: plen_q  <= cfg_data_i;
        swmc_pkg::CFG_MISMATCH_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plen_q == '0) begin
      len_w = swmc_pkg::LEN_W'(1);
    end else if ({3'b000, plen_q} > 9'(MAX_PATTERN)) begin
      len_w = swmc_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      len_w = plen_q;
    end
  end

  // input handshake and position
  assign in_stall_o = state_q != swmc_pkg::ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign prot_acc   = in_accept && req_type_i;
  assign pat_acc    = in_accept && !req_type_i;

  assign pos_base = first_residue_i ? '0 : pos_q;
  assign pos_d    = (pos_base == POS_MAX) ? pos_base : pos_base + 1'b1;
  assign full     = pos_d >= POSITION_BITS'(len_w);
  assign end_w    = 33'(pos_d);
  assign start_w  = end_w - 33'(len_w) + 33'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (prot_acc) begin
      pos_q <= pos_d;
    end
  end

  assign span_en = prot_acc && full;

  always_ff @(posedge clk_i) begin
    if (span_en) begin
      end_q   <= (end_w > 33'd65535) ? '1 : end_w[swmc_pkg::POS_OUT_W-1:0];
      start_q <= (start_w > 33'd65535) ? '1 : start_w[swmc_pkg::POS_OUT_W-1:0];
    end
  end

  // pattern memory
  assign idx_ext = 9'(pattern_index_i);
  assign rd_addr = prot_acc ? AW'(len_w - 1'b1) : k_q - AW'(1);

  always_ff @(posedge clk_i) begin
    if (pat_acc && (idx_ext < 9'(MAX_PATTERN))) begin
      pat_mem[idx_ext[AW-1:0]] <= residue_i;
    end
    pat_rd_q <= pat_mem[rd_addr];
  end

  // window chain
  assign cell_ctrl.shift = prot_acc;
  assign cell_ctrl.step  = state_q == swmc_pkg::ST_COMPARE;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [swmc_pkg::RES_W-1:0] win_nb;
    logic [swmc_pkg::RES_W-1:0] cmp_nb;

    if (j == MAX_PATTERN - 1) begin : g_top
      assign win_nb = residue_i;
    end else begin : g_mid
      assign win_nb = first_residue_i ? '0 : win_w[j+1];
    end

    if (j == 0) begin : g_bottom
      assign cmp_nb = '0;
    end else begin : g_upper
      assign cmp_nb = cmp_w[j-1];
    end

    swmc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .win_nb_i (win_nb),
      .cmp_nb_i (cmp_nb),
      .win_o    (win_w[j]),
      .cmp_o    (cmp_w[j])
    );
  end

  // mismatch count with cap
  assign mismatch  = pat_rd_q != cmp_w[MAX_PATTERN-1];
  assign mism_next = mism_q + swmc_pkg::LEN_W'(mismatch);
  assign cap_w     = {1'b0, limit_q} + 7'd1;
  assign capped    = ({1'b0, mism_next} > cap_w) ? cap_w[swmc_pkg::LEN_W-1:0] : mism_next;
  assign product   = swmc_pkg::PROD_W'(matches_q) *
                     swmc_pkg::PROD_W'(swmc_pkg::HUNDREDTHS_SCALE);

  always_ff @(posedge clk_i) begin
    if (matches_en) begin
      matches_q <= len_w - capped;
    end
  end

  swmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (len_w),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // sequencer
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    mism_d     = mism_q;
    matches_en = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      swmc_pkg::ST_IDLE: begin
        if (span_en) begin
          state_d = swmc_pkg::ST_COMPARE;
          k_d     = AW'(len_w - 1'b1);
          mism_d  = '0;
        end
      end
      swmc_pkg::ST_COMPARE: begin
        mism_d = mism_next;
        if (k_q == '0) begin
          matches_en = 1'b1;
          state_d    = swmc_pkg::ST_START;
        end else begin
          k_d = k_q - AW'(1);
        end
      end
      swmc_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = swmc_pkg::ST_DIVIDE;
      end
      swmc_pkg::ST_DIVIDE: begin
        if (div_done && out_free) begin
          out_load = 1'b1;
          state_d  = swmc_pkg::ST_IDLE;
        end
      end
      default: state_d = swmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swmc_pkg::ST_IDLE;
      k_q     <= '0;
      mism_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      mism_q  <= mism_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      window_start_o        <= start_q;
      window_end_o          <= end_q;
      match_count_o         <= matches_q;
      homology_hundredths_o <= quot;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_hom_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (homology_hundredths_o <= swmc_pkg::HUNDREDTHS_SCALE))
    else $error("homology above full scale");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_start_o <= window_end_o))
    else $error("window start after window end");

  a_mism_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swmc_pkg::ST_COMPARE) |-> (mism_q <= len_w))
    else $error("mismatch count beyond window length");

  a_match_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (matches_q == len_w)) |=>
      (homology_hundredths_o == swmc_pkg::HUNDREDTHS_SCALE))
    else $error("full match not at full scale");

endmodule

// ----- sv/swmc_cell.sv -----
module swmc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  swmc_pkg::cell_ctrl_t             ctrl_i,
  input  logic [swmc_pkg::RES_W-1:0]       win_nb_i,
  input  logic [swmc_pkg::RES_W-1:0]       cmp_nb_i,
  output logic [swmc_pkg::RES_W-1:0]       win_o,
  output logic [swmc_pkg::RES_W-1:0]       cmp_o
);

  logic [swmc_pkg::RES_W-1:0] win_q;
  logic [swmc_pkg::RES_W-1:0] cmp_q;

  // window residue, moves one place towards the oldest end per protein residue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.shift) begin
      win_q <= win_nb_i;
    end
  end

  // scan copy, loaded with the new window and walked towards the newest end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      cmp_q <= win_nb_i;
    end else if (ctrl_i.step) begin
      cmp_q <= cmp_nb_i;
    end
  end

  assign win_o = win_q;
  assign cmp_o = cmp_q;

endmodule

// ----- sv/swmc_div.sv -----
module swmc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [swmc_pkg::PROD_W-1:0]       dividend_i,
  input  logic [swmc_pkg::LEN_W-1:0]        divisor_i,
  output logic                              done_o,
  output logic [swmc_pkg::HOM_W-1:0]        quot_o
);

  logic                              active_q, active_d;
  logic                              done_q, done_d;
  logic [swmc_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [swmc_pkg::PROD_W-1:0]       nq_q, nq_d;
  logic [swmc_pkg::LEN_W-1:0]        rem_q, rem_d;
  logic [swmc_pkg::LEN_W-1:0]        div_q, div_d;
  logic [swmc_pkg::LEN_W:0]          rem_t;
  logic                              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_t    = {rem_q, nq_q[swmc_pkg::PROD_W-1]};
    ge       = rem_t >= {1'b0, div_q};
    active_d = active_q;
    done_d   = done_q;
    cnt_d    = cnt_q;
    nq_d     = nq_q;
    rem_d    = rem_q;
    div_d    = div_q;
    if (start_i) begin
      active_d = 1'b1;
      done_d   = 1'b0;
      cnt_d    = '0;
      nq_d     = dividend_i;
      rem_d    = '0;
      div_d    = divisor_i;
    end else if (active_q) begin
      nq_d  = {nq_q[swmc_pkg::PROD_W-2:0], ge};
      rem_d = ge ? swmc_pkg::LEN_W'(rem_t - {1'b0, div_q})
                 : rem_t[swmc_pkg::LEN_W-1:0];
      if (cnt_q == swmc_pkg::DIV_CNT_W'(swmc_pkg::DIV_STEPS - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = nq_q[swmc_pkg::HOM_W-1:0];

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam real HALF_PERIOD     = 6.0;
  localparam int  RESET_CYCLES    = 6;
  localparam int  WIN             = 32;
  localparam int  SETTLE_CYCLES   = 64;
  localparam int  WATCHDOG_LIMIT  = 4000;
  localparam int  PHASE_ITEMS     = 50;
  localparam int  REPORT_LIMIT    = 10;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_PROTEIN = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic [swmc_pkg::RES_W-1:0] residue;
    logic [swmc_pkg::IDX_W-1:0] pattern_index;
    logic                       first_residue;
  } residue_req_t;

  typedef struct packed {
    logic [swmc_pkg::POS_OUT_W-1:0] window_start;
    logic [swmc_pkg::POS_OUT_W-1:0] window_end;
    logic [swmc_pkg::LEN_W-1:0]     match_count;
    logic [swmc_pkg::HOM_W-1:0]     homology;
  } window_score_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_stall_o;
  logic                           req_type_i      = REQ_PATTERN;
  logic [swmc_pkg::RES_W-1:0]     residue_i       = '0;
  logic [swmc_pkg::IDX_W-1:0]     pattern_index_i = '0;
  logic                           first_residue_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i     = 1'b0;
  logic [swmc_pkg::POS_OUT_W-1:0] window_start_o;
  logic [swmc_pkg::POS_OUT_W-1:0] window_end_o;
  logic [swmc_pkg::LEN_W-1:0]     match_count_o;
  logic [swmc_pkg::HOM_W-1:0]     homology_hundredths_o;
  logic                           cfg_valid_i     = 1'b0;
  logic                           cfg_ready_o;
  logic [swmc_pkg::CFG_IDX_W-1:0] cfg_index_i     = swmc_pkg::CFG_PATTERN_LENGTH;
  logic [swmc_pkg::CFG_W-1:0]     cfg_data_i      = '0;

  sliding_window_mismatch_counter dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .req_type_i            (req_type_i),
    .residue_i             (residue_i),
    .pattern_index_i       (pattern_index_i),
    .first_residue_i       (first_residue_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .window_start_o        (window_start_o),
    .window_end_o          (window_end_o),
    .match_count_o         (match_count_o),
    .homology_hundredths_o (homology_hundredths_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  residue_req_t  residue_q[$];
  window_score_t expected_scores[$];

  // predictor state
  logic [swmc_pkg::RES_W-1:0] m_pattern [WIN];
  logic [swmc_pkg::RES_W-1:0] m_window [WIN];
  logic [15:0]                m_pos   = '0;
  logic [swmc_pkg::CFG_W-1:0] m_len   = 6'd1;
  logic [swmc_pkg::CFG_W-1:0] m_limit = 6'd0;

  // stimulus generator state
  logic [swmc_pkg::RES_W-1:0] gen_pattern [WIN];
  logic [swmc_pkg::RES_W-1:0] gen_alpha [4];
  logic [WIN-1:0]             gen_mask   = '0;
  bit                         gen_narrow = 1'b0;
  int                         queued_items = 0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  fail_count     = 0;
  int  idle_cycles    = 0;
  bit  in_fire        = 1'b0;

  int phase_len   [8] = '{32, 63, 7, 3, 12, 32, 2, 17};
  int phase_limit [8] = '{32, 0, 2, 63, 12, 63, 0, 4};

  initial begin
    foreach (m_window[k]) m_window[k] = '0;
    foreach (m_pattern[k]) m_pattern[k] = '0;
  end

  function automatic int clamp_len(logic [swmc_pkg::CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > WIN) return WIN;
    return v;
  endfunction

  function automatic void flag_error(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  task automatic score_window(input residue_req_t r);
    int unsigned len, miss, hits, pos_start;
    int k;
    window_score_t s;
    if (r.req_type == REQ_PATTERN) begin
      m_pattern[r.pattern_index] = r.residue;
      return;
    end
    if (r.first_residue) begin
      foreach (m_window[j]) m_window[j] = '0;
      m_pos = '0;
    end
    for (k = 0; k < WIN - 1; k++) m_window[k] = m_window[k + 1];
    m_window[WIN - 1] = r.residue;
    if (m_pos != 16'hFFFF) m_pos++;
    len = clamp_len(m_len);
    if (m_pos < len) return;
    miss = 0;
    for (k = 0; k < len; k++) begin
      if (m_pattern[k] != m_window[WIN - len + k]) begin
        miss++;
        if (miss > m_limit) begin
          miss = m_limit + 1;
          break;
        end
      end
    end
    hits = len - miss;
    pos_start = m_pos - len + 1;
    s.window_start = pos_start[swmc_pkg::POS_OUT_W-1:0];
    s.window_end   = m_pos;
    s.match_count  = hits[swmc_pkg::LEN_W-1:0];
    s.homology     = swmc_pkg::HOM_W'((hits * 10000) / len);
    expected_scores.push_back(s);
  endtask

  // driver
  always @(negedge clk_i) begin
    residue_req_t nxt;
    logic drive;
    if (!in_valid_i || in_fire) begin
      drive = 1'b0;
      if (residue_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = residue_q.pop_front();
        drive = 1'b1;
        req_type_i      <= nxt.req_type;
        residue_i       <= nxt.residue;
        pattern_index_i <= nxt.pattern_index;
        first_residue_i <= nxt.first_residue;
      end
      in_valid_i <= drive;
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    window_score_t got, want;
    residue_req_t  taken;
    bit out_fire, req_fire, cfg_fire;
    req_fire = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    cfg_fire = rst_ni && cfg_valid_i && cfg_ready_o;
    in_fire <= req_fire;
    if (out_fire) begin
      got.window_start = window_start_o;
      got.window_end   = window_end_o;
      got.match_count  = match_count_o;
      got.homology     = homology_hundredths_o;
      if (expected_scores.size() == 0) begin
        flag_error($sformatf("unexpected result: start %0d end %0d matches %0d homology %0d",
                             got.window_start, got.window_end, got.match_count,
                             got.homology));
      end else begin
        want = expected_scores.pop_front();
        if (got.window_start !== want.window_start || got.window_end !== want.window_end ||
            got.match_count !== want.match_count || got.homology !== want.homology) begin
          flag_error($sformatf({"result mismatch: expected start %0d end %0d matches %0d ",
                                "homology %0d, got start %0d end %0d matches %0d homology %0d"},
                               want.window_start, want.window_end, want.match_count,
                               want.homology, got.window_start, got.window_end,
                               got.match_count, got.homology));
        end
      end
    end
    if (req_fire) begin
      taken.req_type      = req_type_i;
      taken.residue       = residue_i;
      taken.pattern_index = pattern_index_i;
      taken.first_residue = first_residue_i;
      score_window(taken);
    end
    if (req_fire || out_fire || cfg_fire || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [swmc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swmc_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == swmc_pkg::CFG_PATTERN_LENGTH) m_len = val;
    else m_limit = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    while (residue_q.size() != 0 || in_valid_i || expected_scores.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void set_idling(int mode);
    case (mode)
      1: begin send_idle_pct = 64; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 64; end
      3: begin send_idle_pct = 23; recv_stall_pct = 23; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endfunction

  function automatic void push_pattern(int idx, logic [swmc_pkg::RES_W-1:0] res);
    residue_req_t r;
    r.req_type      = REQ_PATTERN;
    r.residue       = res;
    r.pattern_index = idx[swmc_pkg::IDX_W-1:0];
    r.first_residue = 1'($urandom_range(1));
    residue_q.push_back(r);
    gen_pattern[idx] = res;
    gen_mask[idx]    = 1'b1;
    queued_items++;
  endfunction

  function automatic void push_residue(logic [swmc_pkg::RES_W-1:0] res, bit first);
    residue_req_t r;
    r.req_type      = REQ_PROTEIN;
    r.residue       = res;
    r.pattern_index = swmc_pkg::IDX_W'($urandom_range(WIN - 1));
    r.first_residue = first;
    residue_q.push_back(r);
    queued_items++;
  endfunction

  function automatic bit pattern_covers(int len);
    logic [WIN-1:0] need;
    need = {WIN{1'b1}} >> (WIN - len);
    return (gen_mask & need) == need;
  endfunction

  function automatic logic [swmc_pkg::RES_W-1:0] pick_residue();
    if (gen_narrow) return gen_alpha[$urandom_range(3)];
    return swmc_pkg::RES_W'($urandom_range(255));
  endfunction

  // pattern load when needed or at random, then a protein carrying a mutated copy of the pattern
  task automatic queue_protein(input int len, input bit fresh);
    int k, pre_len, copy_len, suf_len, mut_pct;
    bit down, lead;
    gen_narrow = 1'($urandom_range(1));
    foreach (gen_alpha[a]) gen_alpha[a] = swmc_pkg::RES_W'($urandom_range(255));
    down = 1'($urandom_range(1));
    lead = fresh;
    if (!pattern_covers(len) || $urandom_range(3) == 0) begin
      for (k = 0; k < len; k++) push_pattern(down ? len - 1 - k : k, pick_residue());
    end
    mut_pct  = ($urandom_range(2) == 0) ? 0 : $urandom_range(60);
    pre_len  = $urandom_range(4);
    copy_len = ($urandom_range(3) == 0) ? $urandom_range(len) : len;
    suf_len  = $urandom_range(len / 2 + 1);
    for (k = 0; k < pre_len; k++) begin
      push_residue(pick_residue(), lead);
      lead = 1'b0;
    end
    for (k = 0; k < copy_len; k++) begin
      push_residue(($urandom_range(99) < mut_pct) ? pick_residue() : gen_pattern[k], lead);
      lead = 1'b0;
    end
    for (k = 0; k < suf_len; k++) push_residue(pick_residue(), 1'b0);
  endtask

  task automatic queue_noise(input int len);
    int k, n;
    n = $urandom_range(6, 1);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(1) && pattern_covers(len))
        push_residue(swmc_pkg::RES_W'($urandom_range(255)), $urandom_range(3) == 0);
      else
        push_pattern($urandom_range(WIN - 1), swmc_pkg::RES_W'($urandom_range(255)));
    end
  endtask

  initial begin
    int p, target;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);

    // reset settings: single residue window, no mismatch allowed
    push_pattern(0, 8'hA5);
    push_residue(8'hA5, 1'b1);
    push_residue(8'h00, 1'b0);
    push_residue(8'hFF, 1'b0);
    push_pattern(WIN - 1, 8'hFF);
    push_pattern(0, 8'h00);
    push_residue(8'h00, 1'b0);
    settle();

    // window fills before the first result, cap at two mismatches
    write_reg(swmc_pkg::CFG_PATTERN_LENGTH, 6'd4);
    write_reg(swmc_pkg::CFG_MISMATCH_LIMIT, 6'd1);
    push_pattern(1, 8'h11);
    push_pattern(2, 8'h22);
    push_pattern(3, 8'h33);
    push_residue(8'h00, 1'b1);
    push_residue(8'h11, 1'b0);
    push_residue(8'h99, 1'b0);
    push_residue(8'h98, 1'b0);
    push_residue(8'h33, 1'b0);
    settle();

    // length of zero clamps to one, limit above length, protein carries on
    write_reg(swmc_pkg::CFG_PATTERN_LENGTH, 6'd0);
    write_reg(swmc_pkg::CFG_MISMATCH_LIMIT, 6'd63);
    push_residue(8'h00, 1'b0);
    push_residue(8'h7F, 1'b0);
    settle();

    for (p = 0; p < 8; p++) begin
      set_idling(p % 4);
      write_reg(swmc_pkg::CFG_PATTERN_LENGTH, swmc_pkg::CFG_W'(phase_len[p]));
      write_reg(swmc_pkg::CFG_MISMATCH_LIMIT, swmc_pkg::CFG_W'(phase_limit[p]));
      target = queued_items + PHASE_ITEMS;
      while (queued_items < target) begin
        if ($urandom_range(4) == 0) queue_noise(clamp_len(m_len));
        else queue_protein(clamp_len(m_len), $urandom_range(7) != 0);
      end
      settle();
    end

    // oversized length with a limit at the full window
    set_idling(0);
    write_reg(swmc_pkg::CFG_PATTERN_LENGTH, 6'd63);
    write_reg(swmc_pkg::CFG_MISMATCH_LIMIT, 6'd32);
    queue_protein(WIN, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
